[rtl/atga_pkg.sv]
// shared types and constants for the averaged temperature and gas alarm
`default_nettype none
package atga_pkg;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_TICK_MS        = 3'd0,
    REG_GAS_BLINK_MS   = 3'd1,
    REG_TEMP_BLINK_MS  = 3'd2,
    REG_BOTH_BLINK_MS  = 3'd3,
    REG_THRESH_BASE_C  = 3'd4,
    REG_THRESH_SPAN_C  = 3'd5
  } cfg_reg_t;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int TICK_W     = 10;
  localparam int PERIOD_W   = 16;
  localparam int DEG_W      = 9;
  localparam int ACCUM_W    = 17;

  localparam logic [TICK_W-1:0]   TICK_MS_RST      = 10'd10;
  localparam logic [PERIOD_W-1:0] GAS_BLINK_RST    = 16'd1000;
  localparam logic [PERIOD_W-1:0] TEMP_BLINK_RST   = 16'd500;
  localparam logic [PERIOD_W-1:0] BOTH_BLINK_RST   = 16'd100;
  localparam logic [DEG_W-1:0]    THRESH_BASE_RST  = 9'd20;
  localparam logic [DEG_W-1:0]    THRESH_SPAN_RST  = 9'd30;

  // full-scale temperature in degrees C
  localparam int TEMP_FULL_SCALE_C = 330;

  // one result beat as held in the output queue
  typedef struct packed {
    logic alarm_active;
    logic led_on;
    logic gas_alarm;
    logic temp_alarm;
    logic over_temp_raw;
  } result_t;

endpackage
`default_nettype wire

[rtl/averaged_temp_gas_alarm.sv]
// averaged temperature and gas alarm with blinking led, ring memory and output queue
//
//  channel   direction  handshake               payload
//  in        input      in_valid / in_stall     temp_sample, pot_sample, gas_pin_level,
//                                               test_button
//  out       output     out_valid / out_stall   alarm_active, led_on, gas_alarm,
//                                               temp_alarm, over_temp_raw
//  cfg       input      cfg_we                  cfg_index, cfg_data
//
// new beats are accepted while earlier ones are in flight, up to four in flight or queued;
// a result passes the stage 1, 2 and 3 registers before it enters the output queue
// the ring memory is read when a beat is accepted and written back in the cycle after
// reset is synchronous; in_stall is high during reset
// in_stall rises once the four-entry output queue plus beats in flight are full,
// so a result leaving the queue frees its slot only in the following cycle
`default_nettype none
module averaged_temp_gas_alarm #(
  parameter int AVG_DEPTH = 100,
  parameter int ADC_BITS  = 12
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          in_valid,
  output logic                         in_stall,
  input  wire  [ADC_BITS-1:0]          temp_sample,
  input  wire  [ADC_BITS-1:0]          pot_sample,
  input  wire                          gas_pin_level,
  input  wire                          test_button,
  output logic                         out_valid,
  input  wire                          out_stall,
  output logic                         alarm_active,
  output logic                         led_on,
  output logic                         gas_alarm,
  output logic                         temp_alarm,
  output logic                         over_temp_raw,
  input  wire                          cfg_we,
  input  wire  [atga_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire  [atga_pkg::CFG_DATA_W-1:0] cfg_data
);
  import atga_pkg::*;

  localparam int SLOT_W  = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
  localparam int FILL_W  = $clog2(AVG_DEPTH + 1);
  localparam int SUM_W   = ADC_BITS + FILL_W;
  localparam int CMP_W   = SUM_W + 10;
  localparam int PROD_W  = DEG_W + ADC_BITS;
  localparam int unsigned ADC_FS = (1 << ADC_BITS) - 1;
  localparam int unsigned N_FS   = AVG_DEPTH * ADC_FS;
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = 2;
  localparam int Q_CNT_W = 3;

  // configuration registers
  logic [TICK_W-1:0]   tick_ms;
  logic [PERIOD_W-1:0] gas_blink_ms;
  logic [PERIOD_W-1:0] temp_blink_ms;
  logic [PERIOD_W-1:0] both_blink_ms;
  logic [DEG_W-1:0]    threshold_base_c;
  logic [DEG_W-1:0]    threshold_span_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_ms          <= TICK_MS_RST;
      gas_blink_ms     <= GAS_BLINK_RST;
      temp_blink_ms    <= TEMP_BLINK_RST;
      both_blink_ms    <= BOTH_BLINK_RST;
      threshold_base_c <= THRESH_BASE_RST;
      threshold_span_c <= THRESH_SPAN_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TICK_MS:       tick_ms          <= cfg_data[TICK_W-1:0];
        REG_GAS_BLINK_MS:  gas_blink_ms     <= cfg_data;
        REG_TEMP_BLINK_MS: temp_blink_ms    <= cfg_data;
        REG_BOTH_BLINK_MS: both_blink_ms    <= cfg_data;
        REG_THRESH_BASE_C: threshold_base_c <= cfg_data[DEG_W-1:0];
        REG_THRESH_SPAN_C: threshold_span_c <= cfg_data[DEG_W-1:0];
        default: ;
      endcase
    end
  end

  // output queue bookkeeping
  logic                 s1_valid, s2_valid, s3_valid;
  logic [Q_CNT_W-1:0]   q_count;
  logic [Q_CNT_W-1:0]   in_flight;
  logic                 in_accept;
  logic                 q_pop;

  assign in_flight = Q_CNT_W'(s1_valid) + Q_CNT_W'(s2_valid) + Q_CNT_W'(s3_valid);
  assign in_stall  = rst || ((q_count + in_flight) >= Q_CNT_W'(Q_DEPTH));
  assign in_accept = in_valid && !in_stall;

  // stage 0: ring address and fill tracking
  logic [SLOT_W-1:0]   write_slot;
  logic [FILL_W-1:0]   slots_filled;
  logic [ADC_BITS-1:0] first_sample;
  logic [ADC_BITS-1:0] prev_pot;

  always_ff @(posedge clk) begin
    if (rst) begin
      write_slot   <= '0;
      slots_filled <= '0;
      first_sample <= '0;
      prev_pot     <= '0;
    end else if (in_accept) begin
      write_slot <= (write_slot == SLOT_W'(AVG_DEPTH - 1)) ? '0 : write_slot + 1'b1;
      if (slots_filled != FILL_W'(AVG_DEPTH)) begin
        slots_filled <= slots_filled + 1'b1;
      end
      if (slots_filled == '0) begin
        first_sample <= temp_sample;
      end
      prev_pot <= pot_sample;
    end
  end

  // ring memory
  logic [ADC_BITS-1:0] ring [AVG_DEPTH];
  logic [ADC_BITS-1:0] ring_rd;
  logic                fwd_hit;
  logic [ADC_BITS-1:0] fwd_data;

  // stage 1 registers
  logic [ADC_BITS-1:0] s1_temp;
  logic [ADC_BITS-1:0] s1_prev_pot;
  logic [SLOT_W-1:0]   s1_slot;
  logic                s1_is_first;
  logic                s1_use_first;
  logic                s1_gas;
  logic                s1_test;

  always_ff @(posedge clk) begin
    if (in_accept) begin
      ring_rd <= ring[write_slot];
    end
    if (s1_valid) begin
      ring[s1_slot] <= s1_temp;
    end
  end

  // a write-back to the slot being read in the same cycle bypasses the memory
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_hit <= 1'b0;
    end else begin
      fwd_hit <= s1_valid && in_accept && (s1_slot == write_slot);
    end
    fwd_data <= s1_temp;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_accept;
    end
    if (in_accept) begin
      s1_temp      <= temp_sample;
      s1_prev_pot  <= prev_pot;
      s1_slot      <= write_slot;
      s1_is_first  <= (slots_filled == '0);
      s1_use_first <= (slots_filled != FILL_W'(AVG_DEPTH));
      s1_gas       <= !gas_pin_level || test_button;
      s1_test      <= test_button;
    end
  end

  // stage 1: running sum update and span product
  logic [SUM_W-1:0]    sample_sum;
  logic [ADC_BITS-1:0] old_sample;
  logic [PROD_W-1:0]   s2_span_prod;
  logic                s2_gas;
  logic                s2_test;

  always_comb begin
    if (s1_use_first) begin
      old_sample = first_sample;
    end else if (fwd_hit) begin
      old_sample = fwd_data;
    end else begin
      old_sample = ring_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_sum <= '0;
      s2_valid   <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
      if (s1_valid) begin
        // first beat stands in for every slot
        if (s1_is_first) begin
          sample_sum <= SUM_W'(s1_temp) * SUM_W'(AVG_DEPTH);
        end else begin
          sample_sum <= sample_sum - SUM_W'(old_sample) + SUM_W'(s1_temp);
        end
      end
    end
    s2_span_prod <= PROD_W'(threshold_span_c) * PROD_W'(s1_prev_pot);
    s2_gas       <= s1_gas;
    s2_test      <= s1_test;
  end

  // stage 2: scaled sum against threshold terms
  logic [CMP_W-1:0] s3_lhs;
  logic [CMP_W-1:0] s3_rhs;
  logic             s3_gas;
  logic             s3_test;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else begin
      s3_valid <= s2_valid;
    end
    s3_lhs  <= CMP_W'(sample_sum) * CMP_W'(TEMP_FULL_SCALE_C);
    s3_rhs  <= CMP_W'(N_FS) * CMP_W'(threshold_base_c)
             + CMP_W'(AVG_DEPTH) * CMP_W'(s2_span_prod);
    s3_gas  <= s2_gas;
    s3_test <= s2_test;
  end

  // stage 3: compare, alarms and blink
  logic [ACCUM_W-1:0]  blink_accum_ms;
  logic [ACCUM_W-1:0]  blink_accum_ms_next;
  logic                led_level;
  logic                led_level_next;
  logic [ACCUM_W-1:0]  accum_sum;
  logic [PERIOD_W-1:0] period;
  logic                over;
  logic                hot;
  logic                alarm;
  result_t             res;

  always_comb begin
    over      = s3_lhs > s3_rhs;
    hot       = over || s3_test;
    alarm     = s3_gas || hot;
    accum_sum = blink_accum_ms + ACCUM_W'(tick_ms);
    if (s3_gas && hot) begin
      period = both_blink_ms;
    end else if (s3_gas) begin
      period = gas_blink_ms;
    end else begin
      period = temp_blink_ms;
    end
    blink_accum_ms_next = blink_accum_ms;
    led_level_next      = led_level;
    if (s3_valid) begin
      if (!alarm) begin
        blink_accum_ms_next = '0;
        led_level_next      = 1'b0;
      end else if (accum_sum >= ACCUM_W'(period)) begin
        blink_accum_ms_next = '0;
        led_level_next      = !led_level;
      end else begin
        blink_accum_ms_next = accum_sum;
      end
    end
    res.alarm_active  = alarm;
    res.led_on        = led_level_next;
    res.gas_alarm     = s3_gas;
    res.temp_alarm    = hot;
    res.over_temp_raw = over;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      blink_accum_ms <= '0;
      led_level      <= 1'b0;
    end else begin
      blink_accum_ms <= blink_accum_ms_next;
      led_level      <= led_level_next;
    end
  end

  // output queue
  result_t             q_mem [Q_DEPTH];
  logic [Q_PTR_W-1:0]  q_wr_ptr;
  logic [Q_PTR_W-1:0]  q_rd_ptr;
  result_t             q_head;

  assign q_pop = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_wr_ptr <= '0;
      q_rd_ptr <= '0;
      q_count  <= '0;
    end else begin
      if (s3_valid) begin
        q_wr_ptr <= q_wr_ptr + 1'b1;
      end
      if (q_pop) begin
        q_rd_ptr <= q_rd_ptr + 1'b1;
      end
      q_count <= q_count + Q_CNT_W'(s3_valid) - Q_CNT_W'(q_pop);
    end
    if (s3_valid) begin
      q_mem[q_wr_ptr] <= res;
    end
  end

  assign q_head        = q_mem[q_rd_ptr];
  assign out_valid     = (q_count != '0);
  assign alarm_active  = q_head.alarm_active;
  assign led_on        = q_head.led_on;
  assign gas_alarm     = q_head.gas_alarm;
  assign temp_alarm    = q_head.temp_alarm;
  assign over_temp_raw = q_head.over_temp_raw;

  // queue plus beats in flight never exceed the queue depth
  a_credit: assert property (@(posedge clk) disable iff (rst)
    (q_count + in_flight) <= Q_CNT_W'(Q_DEPTH))
    else $error("output queue overcommitted");

  // led is dark whenever no alarm is on
  a_led_dark: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !alarm_active) |-> !led_on)
    else $error("led lit without alarm");

  // raw over-temperature always shows up as temperature alarm
  a_temp_alarm: assert property (@(posedge clk) disable iff (rst)
    (out_valid && over_temp_raw) |-> (temp_alarm && alarm_active))
    else $error("over-temperature without alarm");

  // fill count saturates at the ring depth
  a_fill: assert property (@(posedge clk) disable iff (rst)
    (slots_filled == FILL_W'(AVG_DEPTH)) |=> (slots_filled == FILL_W'(AVG_DEPTH)))
    else $error("fill count left saturation");

endmodule
`default_nettype wire

[tb/averaged_temp_gas_alarm_checker.sv]
// result checker for the averaged temperature and gas alarm: tracks config, predicts, compares
module averaged_temp_gas_alarm_checker #(
  parameter int AVG_DEPTH = 100,
  parameter int ADC_BITS  = 12
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  logic [ADC_BITS-1:0]             temp_sample,
  input  logic [ADC_BITS-1:0]             pot_sample,
  input  logic                            gas_pin_level,
  input  logic                            test_button,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  logic                            alarm_active,
  input  logic                            led_on,
  input  logic                            gas_alarm,
  input  logic                            temp_alarm,
  input  logic                            over_temp_raw,
  input  logic                            cfg_we,
  input  logic [atga_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [atga_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              fails,
  output int                              pending,
  output int                              checked,
  output int                              over_seen,
  output int                              led_seen
);
  import atga_pkg::*;

  localparam int SUM_W = ADC_BITS + $clog2(AVG_DEPTH);
  localparam longint unsigned ADC_FS = (64'd1 << ADC_BITS) - 64'd1;

  // register copies
  logic [TICK_W-1:0]   tick_ms;
  logic [PERIOD_W-1:0] gas_period, temp_period, both_period;
  logic [DEG_W-1:0]    base_c, span_c;

  // averaging and blink state
  logic [ADC_BITS-1:0] ring [AVG_DEPTH];
  int unsigned         wr_slot, slots_filled;
  logic [SUM_W-1:0]    sample_sum;
  logic [ADC_BITS-1:0] prev_pot;
  logic [ACCUM_W-1:0]  blink_accum;
  logic                led_level;

  result_t alarm_q [$];
  result_t want, seen;

  task automatic predict_alarm_tick(input logic [ADC_BITS-1:0] t, input logic [ADC_BITS-1:0] p,
                                    input logic gas_pin, input logic btn, output result_t r);
    int unsigned k, slot;
    logic [63:0] lhs, rhs;
    logic over, gas, hot, alarm;
    logic [PERIOD_W-1:0] period;
    // the first sample after reset stands in for the whole ring
    if (slots_filled == 0) begin
      for (k = 0; k < AVG_DEPTH; k++) ring[k] = t;
      sample_sum = SUM_W'(t) * SUM_W'(AVG_DEPTH);
    end
    slot = wr_slot;
    sample_sum = sample_sum - SUM_W'(ring[slot]) + SUM_W'(t);
    ring[slot] = t;
    wr_slot = (slot + 1 >= AVG_DEPTH) ? 0 : slot + 1;
    if (slots_filled < AVG_DEPTH) slots_filled++;

    lhs = 64'(sample_sum) * 64'(TEMP_FULL_SCALE_C);
    rhs = 64'(AVG_DEPTH) * ADC_FS * 64'(base_c) + 64'(AVG_DEPTH) * 64'(span_c) * 64'(prev_pot);
    over = lhs > rhs;
    gas = !gas_pin || btn;
    hot = over || btn;
    alarm = gas || hot;

    if (alarm) begin
      blink_accum = blink_accum + ACCUM_W'(tick_ms);
      if (gas && hot) period = both_period;
      else if (gas) period = gas_period;
      else period = temp_period;
      if (blink_accum >= ACCUM_W'(period)) begin
        blink_accum = '0;
        led_level = ~led_level;
      end
    end else begin
      blink_accum = '0;
      led_level = 1'b0;
    end
    prev_pot = p;

    r.alarm_active = alarm;
    r.led_on = led_level;
    r.gas_alarm = gas;
    r.temp_alarm = hot;
    r.over_temp_raw = over;
  endtask

  task automatic check_bit(input string fld, input logic exp_v, input logic got_v);
    if (got_v !== exp_v) begin
      fails++;
      if (fails <= 10)
        $display("result %0d: %s expected %0b got %0b", checked, fld, exp_v, got_v);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      tick_ms = TICK_MS_RST;
      gas_period = GAS_BLINK_RST;
      temp_period = TEMP_BLINK_RST;
      both_period = BOTH_BLINK_RST;
      base_c = THRESH_BASE_RST;
      span_c = THRESH_SPAN_RST;
      wr_slot = 0;
      slots_filled = 0;
      sample_sum = '0;
      prev_pot = '0;
      blink_accum = '0;
      led_level = 1'b0;
      alarm_q.delete();
      fails = 0;
      pending = 0;
      checked = 0;
      over_seen = 0;
      led_seen = 0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_TICK_MS:       tick_ms = cfg_data[TICK_W-1:0];
          REG_GAS_BLINK_MS:  gas_period = cfg_data[PERIOD_W-1:0];
          REG_TEMP_BLINK_MS: temp_period = cfg_data[PERIOD_W-1:0];
          REG_BOTH_BLINK_MS: both_period = cfg_data[PERIOD_W-1:0];
          REG_THRESH_BASE_C: base_c = cfg_data[DEG_W-1:0];
          REG_THRESH_SPAN_C: span_c = cfg_data[DEG_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        predict_alarm_tick(temp_sample, pot_sample, gas_pin_level, test_button, want);
        alarm_q.push_back(want);
      end
      if (out_valid && !out_stall) begin
        seen = '{alarm_active, led_on, gas_alarm, temp_alarm, over_temp_raw};
        if (alarm_q.size() == 0) begin
          fails++;
          if (fails <= 10) $display("result beat with nothing expected: %b", seen);
        end else begin
          want = alarm_q.pop_front();
          check_bit("alarm_active", want.alarm_active, seen.alarm_active);
          check_bit("led_on", want.led_on, seen.led_on);
          check_bit("gas_alarm", want.gas_alarm, seen.gas_alarm);
          check_bit("temp_alarm", want.temp_alarm, seen.temp_alarm);
          check_bit("over_temp_raw", want.over_temp_raw, seen.over_temp_raw);
        end
        checked++;
        if (over_temp_raw) over_seen++;
        if (led_on) led_seen++;
      end
      pending = alarm_q.size();
    end
  end

endmodule

[tb/averaged_temp_gas_alarm_tb.sv]
// testbench top for the averaged temperature and gas alarm: stimulus, config phases, verdict
module averaged_temp_gas_alarm_tb;
  import atga_pkg::*;

  localparam int AVG_DEPTH       = 100;
  localparam int ADC_BITS        = 12;
  localparam int FS              = (1 << ADC_BITS) - 1;
  localparam int PHASES          = 10;
  localparam int ITEMS_PER_PHASE = 111;
  localparam int N_DIRECTED      = 16;
  localparam int SETTLE_CYCLES   = 8;
  localparam logic [CFG_IDX_W-1:0] IDX_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] IDX_SPARE_HI = 3'd7;

  typedef enum int {SHAPE_FLAT, SHAPE_NEAR, SHAPE_NOISE} shape_t;

  logic clk, rst;
  logic in_valid, in_stall, out_valid, out_stall;
  logic [ADC_BITS-1:0] temp_sample, pot_sample;
  logic gas_pin_level, test_button;
  logic alarm_active, led_on, gas_alarm, temp_alarm, over_temp_raw;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int fails, pending, checked, over_seen, led_seen;

  // stimulus shaping state
  logic [DEG_W-1:0] base_c, span_c;
  int pot_lvl, beats_sent, in_phase, ph, len, k, pick, hold;
  logic [ADC_BITS-1:0] flat_lvl, t;
  logic gas_pin, btn, calm;
  logic [2*ADC_BITS+1:0] d;
  shape_t shape;

  averaged_temp_gas_alarm #(.AVG_DEPTH(AVG_DEPTH), .ADC_BITS(ADC_BITS)) u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .temp_sample(temp_sample), .pot_sample(pot_sample),
    .gas_pin_level(gas_pin_level), .test_button(test_button),
    .out_valid(out_valid), .out_stall(out_stall),
    .alarm_active(alarm_active), .led_on(led_on), .gas_alarm(gas_alarm),
    .temp_alarm(temp_alarm), .over_temp_raw(over_temp_raw),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  averaged_temp_gas_alarm_checker #(.AVG_DEPTH(AVG_DEPTH), .ADC_BITS(ADC_BITS)) u_chk (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .temp_sample(temp_sample), .pot_sample(pot_sample),
    .gas_pin_level(gas_pin_level), .test_button(test_button),
    .out_valid(out_valid), .out_stall(out_stall),
    .alarm_active(alarm_active), .led_on(led_on), .gas_alarm(gas_alarm),
    .temp_alarm(temp_alarm), .over_temp_raw(over_temp_raw),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fails(fails), .pending(pending), .checked(checked),
    .over_seen(over_seen), .led_seen(led_seen)
  );

  always #2 clk = ~clk;

  function automatic logic [ADC_BITS-1:0] clip(input int v);
    if (v < 0) return '0;
    if (v > FS) return FS[ADC_BITS-1:0];
    return v[ADC_BITS-1:0];
  endfunction

  // sample code whose running average sits right at the current threshold
  function automatic logic [ADC_BITS-1:0] thresh_code();
    return clip((int'(base_c) * FS + int'(span_c) * pot_lvl) / TEMP_FULL_SCALE_C);
  endfunction

  // {temp, pot, gas pin, button}
  function automatic logic [2*ADC_BITS+1:0] directed_beat(input int n);
    case (n)
      0:  return {12'd1000, 12'd0, 1'b1, 1'b0};   // first sample fills the ring
      1:  return {12'd0, 12'hFFF, 1'b1, 1'b0};
      2:  return {12'd0, 12'd0, 1'b1, 1'b0};
      3:  return {12'hFFF, 12'hFFF, 1'b0, 1'b0};  // gas pin asserted
      4:  return {12'hFFF, 12'd0, 1'b0, 1'b0};
      5:  return {12'd0, 12'hFFF, 1'b0, 1'b1};
      6:  return {12'd0, 12'd0, 1'b1, 1'b1};      // test button alone
      7:  return {12'h555, 12'hAAA, 1'b1, 1'b0};
      8:  return {12'hAAA, 12'h555, 1'b0, 1'b0};
      9:  return {12'hFFF, 12'hFFF, 1'b1, 1'b0};
      10: return {12'd0, 12'd0, 1'b0, 1'b0};
      11: return {12'd0, 12'd0, 1'b0, 1'b1};
      12: return {12'hFFF, 12'd0, 1'b1, 1'b1};
      13: return {12'd0, 12'hFFF, 1'b1, 1'b0};
      14: return {12'd2048, 12'd2048, 1'b0, 1'b0};
      default: return {12'd0, 12'd0, 1'b1, 1'b0};
    endcase
  endfunction

  task automatic send_beat(input logic [ADC_BITS-1:0] ts, input logic [ADC_BITS-1:0] ps,
                           input logic g, input logic b);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 14);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    temp_sample <= ts;
    pot_sample <= ps;
    gas_pin_level <= g;
    test_button <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    beats_sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    if (idx == REG_THRESH_BASE_C) base_c = val[DEG_W-1:0];
    if (idx == REG_THRESH_SPAN_C) span_c = val[DEG_W-1:0];
  endtask

  task automatic write_all(input logic [CFG_DATA_W-1:0] tk, input logic [CFG_DATA_W-1:0] gp,
                           input logic [CFG_DATA_W-1:0] tp, input logic [CFG_DATA_W-1:0] bp,
                           input logic [CFG_DATA_W-1:0] bs, input logic [CFG_DATA_W-1:0] sp);
    write_reg(REG_TICK_MS, tk);
    write_reg(REG_GAS_BLINK_MS, gp);
    write_reg(REG_TEMP_BLINK_MS, tp);
    write_reg(REG_BOTH_BLINK_MS, bp);
    write_reg(REG_THRESH_BASE_C, bs);
    write_reg(REG_THRESH_SPAN_C, sp);
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_period();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return CFG_DATA_W'($urandom_range(1, 60000));
    return CFG_DATA_W'($urandom_range(1, 3000));
  endfunction

  task automatic set_phase(input int n);
    case (n)
      0: ;  // run on reset values first
      1: write_all(16'd1000, 16'd60000, 16'd60000, 16'd60000, 16'd0, 16'd0);
      2: write_all(16'd1, 16'd1, 16'd1, 16'd1, 16'd330, 16'd0);
      3: write_all(16'd0, 16'd0, 16'd5, 16'd0, 16'd330, 16'd330);
      4: begin
        // every data bit set; narrow registers keep their low bits only
        write_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        write_reg(IDX_SPARE_LO, 16'h0000);
        write_reg(IDX_SPARE_HI, 16'hFFFF);
      end
      default: write_all(($urandom_range(0, 7) == 0) ? 16'd0 : 16'($urandom_range(1, 1000)),
                         pick_period(), pick_period(), pick_period(),
                         16'($urandom_range(0, 330)), 16'($urandom_range(0, 330)));
    endcase
    cfg_we <= 1'b0;
  endtask

  // result side: random stall after each taken beat
  always begin
    @(posedge clk);
    if (out_valid && !out_stall) begin
      @(negedge clk);
      hold = calm ? 0 : $urandom_range(0, 14);
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    #2000000;
    $display("timeout with %0d results still expected", pending);
    $display("averaged_temp_gas_alarm_tb NOT OK");
    $finish;
  end

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    in_valid = 1'b0;
    temp_sample = '0;
    pot_sample = '0;
    gas_pin_level = 1'b1;
    test_button = 1'b0;
    out_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    base_c = THRESH_BASE_RST;
    span_c = THRESH_SPAN_RST;
    pot_lvl = 0;
    gas_pin = 1'b1;
    btn = 1'b0;
    calm = 1'b0;
    beats_sent = 0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (ph = 0; ph < PHASES; ph++) begin
      if (ph != 0) drain_results();
      set_phase(ph);
      in_phase = 0;
      if (ph == 0) begin
        for (k = 0; k < N_DIRECTED; k++) begin
          d = directed_beat(k);
          send_beat(d[25:14], d[13:2], d[1], d[0]);
          in_phase++;
        end
      end
      while (in_phase < ITEMS_PER_PHASE) begin
        if (ph == 2 && in_phase == 0) begin
          // full-scale plateau lands exactly on the threshold: not over
          shape = SHAPE_FLAT;
          flat_lvl = FS[ADC_BITS-1:0];
          len = AVG_DEPTH + 10;
        end else begin
          pick = $urandom_range(0, 3);
          shape = (pick == 0) ? SHAPE_FLAT : (pick == 1) ? SHAPE_NOISE : SHAPE_NEAR;
          len = $urandom_range(8, 40);
          pick = $urandom_range(0, 3);
          flat_lvl = (pick == 0) ? '0 : (pick == 1) ? FS[ADC_BITS-1:0] :
                     (pick == 2) ? thresh_code() : ADC_BITS'($urandom_range(0, FS));
        end
        calm = ($urandom_range(0, 3) == 0);
        repeat (len) begin
          case (shape)
            SHAPE_FLAT: t = flat_lvl;
            SHAPE_NEAR: begin
              pot_lvl = clip(pot_lvl + int'($urandom_range(0, 120)) - 60);
              t = clip(int'(thresh_code()) + int'($urandom_range(0, 200)) - 100);
            end
            default: begin
              pot_lvl = $urandom_range(0, FS);
              t = ADC_BITS'($urandom_range(0, FS));
              gas_pin = 1'($urandom_range(0, 1));
              btn = ($urandom_range(0, 3) == 0);
            end
          endcase
          // alarms mostly hold for long stretches so the led gets to blink
          if (shape != SHAPE_NOISE) begin
            if ($urandom_range(0, 29) == 0) gas_pin = ~gas_pin;
            if ($urandom_range(0, 49) == 0) btn = ~btn;
          end
          send_beat(t, pot_lvl[ADC_BITS-1:0], gas_pin, btn);
          in_phase++;
        end
        // now and then hold the sender until every result is back
        if ($urandom_range(0, 4) == 0) drain_results();
      end
    end
    calm = 1'b1;
    drain_results();

    $display("%0d input beats over %0d register settings, %0d results checked",
             beats_sent, PHASES, checked);
    $display("over-temperature flagged in %0d results, led lit in %0d", over_seen, led_seen);
    if (fails == 0) begin
      $display("averaged_temp_gas_alarm_tb OK");
    end else begin
      $display("averaged_temp_gas_alarm_tb NOT OK");
    end
    $finish;
  end

endmodule
